// File: rtl/sri_pkg.sv
// Shared types and constants for the segment / window touch test.
`timescale 1ns / 1ps

package sri_pkg;

   // Coordinate width; taken from the low bits of each 32-bit field.
   localparam int COORD_BITS = 32;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;

   // Register index, from paddr[3:2].
   typedef enum logic [1:0] {
      REG_LEFT   = 2'd0,
      REG_TOP    = 2'd1,
      REG_RIGHT  = 2'd2,
      REG_BOTTOM = 2'd3
   } reg_idx_type;

   // Products for one side, ready for the final sum and sign check.
   typedef struct packed {
      logic     crossing;   // exactly one end beyond the side line
      logic     du_neg;     // direction across the side line is negative
      prod_type near_prod;  // (v1 - lo) * du
      prod_type far_prod;   // (v1 - hi) * du
      prod_type cross_prod; // dv * (X - u1)
   } side_prod_type;

endpackage

// File: rtl/segment_rect_intersect_test.sv
// Top level of the segment versus window rectangle touch test.
`timescale 1ns / 1ps

// Segment / window touch test. Each request carries a segment as two end
// points (signed 32-bit map units); the block answers touches = 1 when
// either end lies inside the window or on its edge, or when the segment
// crosses the line of the left, right, top or bottom side within that
// side's span, ends included. The window comes from four registers on the
// csr_ port (left 0x0, top 0x4, right 0x8, bottom 0xC, all reset to 0);
// the window is expected normalised (left <= right, top <= bottom), and
// registers are to be written by the user only while no request is in
// flight; the block does not enforce this. Crossing points are compared
// exactly by cross-multiplication, so there is no rounding. One request
// is taken and one response leaves per clock while the response is not
// stalled; each request passes four registers: input register,
// differences, eight 33x33 signed products, then the sum and sign check
// into the response register. A stalled response holds the pipe only as
// far back as there are no bubbles to fill.
module segment_rect_intersect_test
   import sri_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [31:0]              req_x_start,
   input  logic [31:0]              req_y_start,
   input  logic [31:0]              req_x_end,
   input  logic [31:0]              req_y_end,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_touches,

   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // ---------------------------------------------------------------
   // Window registers
   // ---------------------------------------------------------------
   coord_type   rect_left_ff, rect_top_ff, rect_right_ff, rect_bottom_ff;
   reg_idx_type csr_idx;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_idx_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_left_ff   <= '0;
         rect_top_ff    <= '0;
         rect_right_ff  <= '0;
         rect_bottom_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_LEFT:   rect_left_ff   <= coord_type'(csr_pwdata[COORD_BITS-1:0]);
            REG_TOP:    rect_top_ff    <= coord_type'(csr_pwdata[COORD_BITS-1:0]);
            REG_RIGHT:  rect_right_ff  <= coord_type'(csr_pwdata[COORD_BITS-1:0]);
            REG_BOTTOM: rect_bottom_ff <= coord_type'(csr_pwdata[COORD_BITS-1:0]);
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_LEFT:   csr_prdata = CSR_DATA_BITS'(rect_left_ff);
         REG_TOP:    csr_prdata = CSR_DATA_BITS'(rect_top_ff);
         REG_RIGHT:  csr_prdata = CSR_DATA_BITS'(rect_right_ff);
         REG_BOTTOM: csr_prdata = CSR_DATA_BITS'(rect_bottom_ff);
      endcase
   end

   // ---------------------------------------------------------------
   // Pipeline flow: a stage loads when empty or when it is emptying.
   // ---------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_take, s2_take, s3_take, rsp_take;

   assign rsp_take  = !rsp_valid_ff || rsp_ready;
   assign s3_take   = !s3_valid_ff || rsp_take;
   assign s2_take   = !s2_valid_ff || s3_take;
   assign s1_take   = !s1_valid_ff || s2_take;
   assign req_ready = s1_take;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_take) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_take) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_take) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rsp_take) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: request register
   // ---------------------------------------------------------------
   coord_type x1_ff, y1_ff, x2_ff, y2_ff;

   always_ff @(posedge clock) begin
      if (req_valid && s1_take) begin
         x1_ff <= coord_type'(req_x_start[COORD_BITS-1:0]);
         y1_ff <= coord_type'(req_y_start[COORD_BITS-1:0]);
         x2_ff <= coord_type'(req_x_end[COORD_BITS-1:0]);
         y2_ff <= coord_type'(req_y_end[COORD_BITS-1:0]);
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: differences, inside test, side-line crossings
   // ---------------------------------------------------------------
   logic     inside_in, inside2_ff;
   logic     cross_l_in, cross_r_in, cross_t_in, cross_b_in;
   logic     cross_l_ff, cross_r_ff, cross_t_ff, cross_b_ff;
   diff_type dx_ff, dy_ff;
   diff_type y1t_ff, y1b_ff, x1l_ff, x1r_ff;
   diff_type lx1_ff, rx1_ff, ty1_ff, by1_ff;

   assign inside_in =
      (x1_ff >= rect_left_ff && x1_ff <= rect_right_ff &&
       y1_ff >= rect_top_ff  && y1_ff <= rect_bottom_ff) ||
      (x2_ff >= rect_left_ff && x2_ff <= rect_right_ff &&
       y2_ff >= rect_top_ff  && y2_ff <= rect_bottom_ff);

   // A side line is crossed when exactly one end lies beyond it
   assign cross_l_in = (x1_ff > rect_left_ff)   != (x2_ff > rect_left_ff);
   assign cross_r_in = (x1_ff > rect_right_ff)  != (x2_ff > rect_right_ff);
   assign cross_t_in = (y1_ff > rect_top_ff)    != (y2_ff > rect_top_ff);
   assign cross_b_in = (y1_ff > rect_bottom_ff) != (y2_ff > rect_bottom_ff);

   always_ff @(posedge clock) begin
      if (s2_take) begin
         inside2_ff <= inside_in;
         cross_l_ff <= cross_l_in;
         cross_r_ff <= cross_r_in;
         cross_t_ff <= cross_t_in;
         cross_b_ff <= cross_b_in;
         dx_ff      <= diff_type'(x2_ff) - diff_type'(x1_ff);
         dy_ff      <= diff_type'(y2_ff) - diff_type'(y1_ff);
         y1t_ff     <= diff_type'(y1_ff) - diff_type'(rect_top_ff);
         y1b_ff     <= diff_type'(y1_ff) - diff_type'(rect_bottom_ff);
         x1l_ff     <= diff_type'(x1_ff) - diff_type'(rect_left_ff);
         x1r_ff     <= diff_type'(x1_ff) - diff_type'(rect_right_ff);
         lx1_ff     <= diff_type'(rect_left_ff) - diff_type'(x1_ff);
         rx1_ff     <= diff_type'(rect_right_ff) - diff_type'(x1_ff);
         ty1_ff     <= diff_type'(rect_top_ff) - diff_type'(y1_ff);
         by1_ff     <= diff_type'(rect_bottom_ff) - diff_type'(y1_ff);
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: products. Span-end terms are shared by opposite sides.
   // ---------------------------------------------------------------
   side_prod_type side_l_ff, side_r_ff, side_t_ff, side_b_ff;
   logic          inside3_ff;
   prod_type      p_y1t_dx_in, p_y1b_dx_in, p_x1l_dy_in, p_x1r_dy_in;

   assign p_y1t_dx_in = prod_type'(y1t_ff) * prod_type'(dx_ff);
   assign p_y1b_dx_in = prod_type'(y1b_ff) * prod_type'(dx_ff);
   assign p_x1l_dy_in = prod_type'(x1l_ff) * prod_type'(dy_ff);
   assign p_x1r_dy_in = prod_type'(x1r_ff) * prod_type'(dy_ff);

   always_ff @(posedge clock) begin
      if (s3_take) begin
         inside3_ff <= inside2_ff;

         // Vertical sides: u = x, v = y, span top..bottom
         side_l_ff.crossing   <= cross_l_ff;
         side_l_ff.du_neg     <= dx_ff[DIFF_BITS-1];
         side_l_ff.near_prod  <= p_y1t_dx_in;
         side_l_ff.far_prod   <= p_y1b_dx_in;
         side_l_ff.cross_prod <= prod_type'(dy_ff) * prod_type'(lx1_ff);

         side_r_ff.crossing   <= cross_r_ff;
         side_r_ff.du_neg     <= dx_ff[DIFF_BITS-1];
         side_r_ff.near_prod  <= p_y1t_dx_in;
         side_r_ff.far_prod   <= p_y1b_dx_in;
         side_r_ff.cross_prod <= prod_type'(dy_ff) * prod_type'(rx1_ff);

         // Horizontal sides: u = y, v = x, span left..right
         side_t_ff.crossing   <= cross_t_ff;
         side_t_ff.du_neg     <= dy_ff[DIFF_BITS-1];
         side_t_ff.near_prod  <= p_x1l_dy_in;
         side_t_ff.far_prod   <= p_x1r_dy_in;
         side_t_ff.cross_prod <= prod_type'(dx_ff) * prod_type'(ty1_ff);

         side_b_ff.crossing   <= cross_b_ff;
         side_b_ff.du_neg     <= dy_ff[DIFF_BITS-1];
         side_b_ff.near_prod  <= p_x1l_dy_in;
         side_b_ff.far_prod   <= p_x1r_dy_in;
         side_b_ff.cross_prod <= prod_type'(dx_ff) * prod_type'(by1_ff);
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: span checks and response register
   // ---------------------------------------------------------------
   logic hit_l, hit_r, hit_t, hit_b;
   logic rsp_touches_ff, touches_in;

   sri_side_eval u_side_l (.side(side_l_ff), .hit(hit_l));
   sri_side_eval u_side_r (.side(side_r_ff), .hit(hit_r));
   sri_side_eval u_side_t (.side(side_t_ff), .hit(hit_t));
   sri_side_eval u_side_b (.side(side_b_ff), .hit(hit_b));

   assign touches_in = inside3_ff || hit_l || hit_r || hit_t || hit_b;

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         rsp_touches_ff <= touches_in;
      end
   end

   assign rsp_touches = rsp_touches_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_touches_ff))
      else $error("response dropped or changed while stalled");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff && !rsp_ready
      |-> !req_ready)
      else $error("request taken with pipe full and output stalled");

   a_cross_dx: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && (cross_l_ff || cross_r_ff) |-> dx_ff != '0)
      else $error("vertical side crossing with zero x extent");

   a_cross_dy: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && (cross_t_ff || cross_b_ff) |-> dy_ff != '0)
      else $error("horizontal side crossing with zero y extent");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipe not empty after reset");

endmodule

// File: rtl/sri_side_eval.sv
// Final sum and span check for one side of the window.
`timescale 1ns / 1ps

module sri_side_eval
   import sri_pkg::*;
(
   input  side_prod_type side,
   output logic          hit
);

   sum_type off_lo;
   sum_type off_hi;
   logic    lo_pos, lo_neg, hi_pos, hi_neg;

   // Scaled offsets of the crossing point from the span ends
   assign off_lo = sum_type'(side.near_prod) + sum_type'(side.cross_prod);
   assign off_hi = sum_type'(side.far_prod) + sum_type'(side.cross_prod);

   assign lo_neg = off_lo[SUM_BITS-1];
   assign hi_neg = off_hi[SUM_BITS-1];
   assign lo_pos = !lo_neg && (off_lo != '0);
   assign hi_pos = !hi_neg && (off_hi != '0);

   // Offsets carry the sign of du; flip the sense when du is negative
   always_comb begin
      if (side.du_neg) begin
         hit = side.crossing && !lo_pos && !hi_neg;
      end else begin
         hit = side.crossing && !lo_neg && !hi_pos;
      end
   end

endmodule
